/* rtl/core/mtss_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mtss_pkg;

  // Fixed field widths.
  localparam int SAMPLE_W    = 18;
  localparam int GAIN_W      = 15;
  localparam int ROM_W       = 15;
  localparam int FRAC_BITS   = 15;
  localparam int PROD_W      = ROM_W + GAIN_W;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;

  // Pi in Q30, used only while the sine table is built.
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // What one cell hands to the next one: a sample in flight and its partial sum.
  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] sum;
  } mtss_link_t;

  // One point of the quarter-wave sine table, 0..32767. The series is a Q30
  // Taylor expansion of nine terms; it is evaluated only at elaboration.
  function automatic logic [ROM_W-1:0] quarter_point(input int k, input int addr_bits);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    begin
      x    = (PI_Q30 * 64'(k)) >> (addr_bits - 1);
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 8; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        case (n)
          1: term = term / 64'd6;
          2: term = term / 64'd20;
          3: term = term / 64'd42;
          4: term = term / 64'd72;
          5: term = term / 64'd110;
          6: term = term / 64'd156;
          7: term = term / 64'd210;
          default: term = term / 64'd272;
        endcase
        if ((n % 2) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      return v[ROM_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/core/multi_tone_sine_synthesizer_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Multi-tone sine synthesizer. Each transfer on the input channel
// (in_valid/in_ready, field tick) with tick set asks for one output sample;
// a transfer with tick clear is taken and dropped without any effect.
// Every tone owns one cell of a chain. As a sample request passes a cell,
// the cell advances its phase accumulator by its step, looks up the sine
// of the top phase bits in a quarter-wave table, scales it by its gain and
// adds the result to the partial sum it hands to the next cell.
// Each cell has four stages (s1, s2, s3 and link_out), and the output
// buffer registers the sample behind the last cell. One sample request
// is taken every cycle while in_ready is high.
// The output side holds the sample in an output register backed by one
// skid register. When the receiver stalls, the chain keeps running until
// both are occupied; then in_ready drops and the whole chain holds.
// in_ready is a registered signal and does not depend on out_ready.
// Tone steps and gains must be written through cfg_we/cfg_index/cfg_data
// (even index: step, odd index: gain) while no sample is in flight; the
// block does not check it. Synchronous reset clears all steps, gains and
// phase accumulators and empties the chain; the block is ready right after.

module multi_tone_sine_synthesizer_core
  import mtss_pkg::*;
#(
  parameter int TONES          = 4,
  parameter int PHASE_BITS     = 32,
  parameter int SINE_ADDR_BITS = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       tick,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [SAMPLE_W-1:0]      sample
);

  // Chain enable: the cells advance whenever the skid register is free.
  logic ce;
  logic full;

  // link[t] enters cell t; link[TONES] leaves the last cell.
  mtss_link_t link [TONES+1];

  assign ce       = ~full;
  assign in_ready = ce;

  // A transfer with tick set injects a request with an empty partial sum.
  assign link[0].valid = in_valid & in_ready & tick;
  assign link[0].sum   = '0;

  for (genvar t = 0; t < TONES; t++) begin : g_cell
    mtss_cell #(
      .PHASE_BITS     (PHASE_BITS),
      .SINE_ADDR_BITS (SINE_ADDR_BITS),
      .TONE_INDEX     (t)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ce        (ce),
      .cfg_we    (cfg_we),
      .cfg_index (cfg_index),
      .cfg_data  (cfg_data),
      .link_in   (link[t]),
      .link_out  (link[t+1])
    );
  end

  // The last cell's register is only pushed on an enabled edge, so a
  // request that waits there during a stall is delivered exactly once.
  mtss_out_buf u_out_buf (
    .clk         (clk),
    .rst         (rst),
    .push_valid  (link[TONES].valid & ce),
    .push_sample (link[TONES].sum),
    .full        (full),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample      (sample)
  );

  // After reset the block is empty and ready.
  a_reset_empty : assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("block not empty and ready after reset");

  // The skid register only fills behind an occupied output register.
  a_full_has_head : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no sample on the output");

  // Four tones of at most full scale never leave the sample range.
  a_sample_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sample >= -18'sd131068 && sample <= 18'sd131068))
    else $error("sample outside the range of four full-scale tones");

endmodule

`default_nettype wire

/* rtl/core/mtss_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module mtss_cell
  import mtss_pkg::*;
#(
  parameter int PHASE_BITS     = 32,
  parameter int SINE_ADDR_BITS = 10,
  parameter int TONE_INDEX     = 0
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   ce,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire mtss_link_t             link_in,
  output mtss_link_t                  link_out
);

  localparam int QB   = SINE_ADDR_BITS - 2;
  localparam int QLEN = 1 << QB;
  localparam logic [CFG_INDEX_W-1:0] StepIndex = CFG_INDEX_W'(2 * TONE_INDEX);
  localparam logic [CFG_INDEX_W-1:0] GainIndex = CFG_INDEX_W'(2 * TONE_INDEX + 1);
  localparam logic [PROD_W-1:0] RoundUp = PROD_W'((1 << FRAC_BITS) - 1);

  logic [PHASE_BITS-1:0] step;
  logic [GAIN_W-1:0]     gain;
  logic [PHASE_BITS-1:0] phase;

  mtss_link_t s1;
  mtss_link_t s2;
  mtss_link_t s3;

  logic [ROM_W-1:0]  mag;
  logic              s2_neg;
  logic [PROD_W-1:0] prod;
  logic              s3_neg;

  // Quarter-wave table, one point more than a quarter so that the mirrored
  // lookup reaches the peak.
  logic [ROM_W-1:0] qrom [QLEN+1];

  for (genvar k = 0; k <= QLEN; k++) begin : g_rom
    assign qrom[k] = quarter_point(k, SINE_ADDR_BITS);
  end

  logic [SINE_ADDR_BITS-1:0] addr;
  logic [QB:0]               rom_idx;
  logic [PROD_W-1:0]         prod_up;
  logic signed [SAMPLE_W-1:0] contrib;

  assign addr    = phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
  assign rom_idx = addr[QB] ? ((QB+1)'(QLEN) - {1'b0, addr[QB-1:0]}) : {1'b0, addr[QB-1:0]};
  assign prod_up = prod + RoundUp;
  assign contrib = s3_neg ? -$signed(SAMPLE_W'(prod_up[PROD_W-1:FRAC_BITS]))
                          :  $signed(SAMPLE_W'(prod[PROD_W-1:FRAC_BITS]));

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      gain <= '0;
    end else if (cfg_we) begin
      if (cfg_index == StepIndex) begin
        step <= cfg_data[PHASE_BITS-1:0];
      end
      if (cfg_index == GainIndex) begin
        gain <= cfg_data[GAIN_W-1:0];
      end
    end
  end

  // The phase advances as the sample passes the first stage of this cell.
  // Only the valid bits and the phase are reset; the data stages just follow.
  always_ff @(posedge clk) begin
    if (ce) begin
      s1.sum       <= link_in.sum;
      s2.sum       <= s1.sum;
      mag          <= qrom[rom_idx];
      s2_neg       <= addr[SINE_ADDR_BITS-1];
      s3.sum       <= s2.sum;
      prod         <= PROD_W'(mag) * PROD_W'(gain);
      s3_neg       <= s2_neg;
      link_out.sum <= s3.sum + contrib;
    end
    if (rst) begin
      phase       <= '0;
      s1.valid    <= 1'b0;
      s2.valid    <= 1'b0;
      s3.valid    <= 1'b0;
      link_out.valid <= 1'b0;
    end else if (ce) begin
      if (link_in.valid) begin
        phase <= phase + step;
      end
      s1.valid       <= link_in.valid;
      s2.valid       <= s1.valid;
      s3.valid       <= s2.valid;
      link_out.valid <= s3.valid;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mtss_out_buf.sv */
`timescale 1ns / 1ps
`default_nettype none

module mtss_out_buf
  import mtss_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push_valid,
  input  wire logic signed [SAMPLE_W-1:0] push_sample,
  output logic                            full,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [SAMPLE_W-1:0]      sample
);

  logic                       skid_valid;
  logic signed [SAMPLE_W-1:0] skid_sample;
  logic                       pop;
  logic                       push;

  assign full = skid_valid;
  assign pop  = out_valid & out_ready;
  assign push = push_valid & ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid) begin
      out_valid <= push;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        sample <= skid_sample;
      end else if (push) begin
        sample <= push_sample;
      end
    end
    if (push && out_valid && (skid_valid || !pop)) begin
      skid_sample <= push_sample;
    end
  end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top
  import mtss_pkg::*;
;

  // Same configuration as the default build of the core.
  localparam int TONES          = 4;
  localparam int PHASE_BITS     = 32;
  localparam int SINE_ADDR_BITS = 10;

  localparam int QUARTER_BITS = SINE_ADDR_BITS - 2;
  localparam int QUARTER_LEN  = 1 << QUARTER_BITS;

  // Pi in Q30, the angle scale of the quarter-wave series.
  localparam logic [63:0] ANGLE_PI_Q30 = 64'd3373259426;

  // A tick travels through four stages per tone. Ticks that carry no sample
  // never enter the chain, yet every drain still waits out this margin before
  // the core is taken as idle.
  localparam int DRAIN_CYCLES = 4 * TONES + 8;

  // Random part: six runs of ticks, each behind a fresh tone setting.
  localparam int RAND_SEGMENTS = 6;
  localparam int SEG_ITEMS     = 316;

  // Far above the slowest legal run, including long random stalls.
  localparam int CYCLE_LIMIT = 400000;

  // Register map of the configuration port: even index is a step, odd a gain.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TONE0_STEP,
    REG_TONE0_GAIN,
    REG_TONE1_STEP,
    REG_TONE1_GAIN,
    REG_TONE2_STEP,
    REG_TONE2_GAIN,
    REG_TONE3_STEP,
    REG_TONE3_GAIN
  } cfg_reg_t;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data  = '0;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  logic                       tick      = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;

  // Ticks waiting to be offered, and the samples the core owes us, in order.
  logic                       pending_ticks[$];
  logic signed [SAMPLE_W-1:0] expected_samples[$];

  // Our own copy of the tone settings and phase accumulators.
  logic [PHASE_BITS-1:0] tone_step_cfg[TONES];
  logic [GAIN_W-1:0]     tone_gain_cfg[TONES];
  logic [PHASE_BITS-1:0] tone_phase[TONES];
  logic [ROM_W-1:0]      sine_quarter[0:QUARTER_LEN];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // Appends one tick to the end of the send queue.
  function automatic void add_pending_tick(input logic t);
    pending_ticks = {pending_ticks, t};
  endfunction

  // Appends one owed sample to the end of the check queue.
  function automatic void add_expected_sample(input logic signed [SAMPLE_W-1:0] s);
    expected_samples = {expected_samples, s};
  endfunction

  multi_tone_sine_synthesizer_core #(
    .TONES          (TONES),
    .PHASE_BITS     (PHASE_BITS),
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .tick      (tick),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // One point of the quarter sine wave: a nine-term Taylor series in Q30,
  // evaluated at k/QUARTER_LEN of a quarter turn, rounded to Q0.15 and
  // clamped so that the peak stays at 32767.
  function automatic logic [ROM_W-1:0] quarter_wave_point(input int unsigned k);
    logic [63:0] angle;
    logic [63:0] term;
    logic [63:0] mag;
    longint      series;
    angle  = (ANGLE_PI_Q30 * 64'(k)) >> (SINE_ADDR_BITS - 1);
    term   = angle;
    series = longint'(angle);
    for (int n = 1; n <= 8; n++) begin
      term = (term * angle) >> 30;
      term = (term * angle) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        series -= longint'(term);
      end else begin
        series += longint'(term);
      end
    end
    if (series < 0) begin
      series = 0;
    end
    mag = (64'(series) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return mag[ROM_W-1:0];
  endfunction

  // Advances every tone by its step and returns the summed sample. The sine
  // of the top phase bits comes from the quarter table by quadrant symmetry.
  // Positive products round down; negative ones are scaled as magnitudes
  // rounded up, which is a floor of the signed product.
  function automatic logic signed [SAMPLE_W-1:0] synth_next_sample();
    int          total;
    int unsigned addr;
    int unsigned quad;
    int unsigned pos;
    int unsigned mag;
    total = 0;
    for (int t = 0; t < TONES; t++) begin
      tone_phase[t] = tone_phase[t] + tone_step_cfg[t];
      addr = int'(tone_phase[t] >> (PHASE_BITS - SINE_ADDR_BITS));
      quad = (addr >> QUARTER_BITS) & 3;
      pos  = addr & (QUARTER_LEN - 1);
      mag  = (quad & 1) ? sine_quarter[QUARTER_LEN - pos] : sine_quarter[pos];
      if ((quad & 2) == 0) begin
        total += int'((mag * tone_gain_cfg[t]) >> FRAC_BITS);
      end else begin
        total -= int'((mag * tone_gain_cfg[t] + 32767) >> FRAC_BITS);
      end
    end
    return total[SAMPLE_W-1:0];
  endfunction

  // Sender. A tick stays on the port until it is taken; the next one may be
  // offered at the very edge of the transfer, or held back to make a gap.
  // Every tick that is taken with its bit set owes one sample.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready && tick) begin
        add_expected_sample(synth_next_sample());
      end
      if (!in_valid || in_ready) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          tick     <= pending_ticks.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Each sample transfer is matched with the oldest sample owed;
  // out_ready is drawn afresh every cycle to stall the output at random.
  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          mismatch_count++;
          $display("%0t: sample with none owed, expected none, actual %0d", $time, sample);
        end else begin
          want = expected_samples.pop_front();
          if (sample !== want) begin
            mismatch_count++;
            $display("%0t: sample mismatch, expected %0d, actual %0d", $time, want, sample);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // A register write takes effect at the next edge. Our copy keeps only the
  // bits the core uses: the full phase width of a step, 15 bits of a gain.
  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] data);
    int t;
    t = int'(r) >> 1;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= data;
    if (int'(r) % 2 == 1) begin
      tone_gain_cfg[t] = data[GAIN_W-1:0];
    end else begin
      tone_step_cfg[t] = data[PHASE_BITS-1:0];
    end
  endtask

  // Waits until every tick has been sent and every owed sample has come, then
  // keeps the ports idle for the drain margin; the chain is already empty by then.
  task automatic drain_sample_path();
    while (pending_ticks.size() != 0 || in_valid || expected_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Draws a new tone setting. Gains keep random upper bits so that the core
  // has to drop them; steps favor a few shapes besides plain random ones:
  // frozen, quarter turn, one step short of a full turn, slow drift, and
  // whole sine-table addresses.
  task automatic load_random_setting(input bit every_reg);
    logic [CFG_DATA_W-1:0] data;
    for (int r = REG_TONE0_STEP; r <= REG_TONE3_GAIN; r++) begin
      if (every_reg || $urandom_range(99) < 70) begin
        data = $urandom;
        if (r % 2 == 1) begin
          case ($urandom_range(5))
            0: data[GAIN_W-1:0] = '0;
            1: data[GAIN_W-1:0] = '1;
            default: ;
          endcase
        end else begin
          case ($urandom_range(7))
            0: data = '0;
            1: data = 32'h4000_0000;
            2: data = '1;
            3: data = $urandom_range(4096);
            4: data = $urandom << (PHASE_BITS - SINE_ADDR_BITS);
            default: ;
          endcase
        end
        write_reg(cfg_reg_t'(r), data);
      end
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    for (int t = 0; t < TONES; t++) begin
      tone_step_cfg[t] = '0;
      tone_gain_cfg[t] = '0;
      tone_phase[t]    = '0;
    end
    for (int k = 0; k <= QUARTER_LEN; k++) begin
      sine_quarter[k] = quarter_wave_point(k);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Straight out of reset all gains are zero, so every sample is silent,
    // and a tick with its bit clear must not produce anything.
    add_pending_tick(1'b1);
    add_pending_tick(1'b0);
    add_pending_tick(1'b1);
    drain_sample_path();

    // All tones at full gain with a quarter-turn step walk the four quadrants
    // in lockstep: positive peak, zero, negative peak, zero. The negative peak
    // is the low bound of the asserted sample range. The gain data carries
    // junk in its upper bits that the core must mask off.
    write_reg(REG_TONE0_STEP, 32'h4000_0000);
    write_reg(REG_TONE1_STEP, 32'h4000_0000);
    write_reg(REG_TONE2_STEP, 32'h4000_0000);
    write_reg(REG_TONE3_STEP, 32'h4000_0000);
    write_reg(REG_TONE0_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_TONE1_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_TONE2_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_TONE3_GAIN, 32'hFFFF_FFFF);
    @(posedge clk);
    cfg_we <= 1'b0;
    add_pending_tick(1'b1);
    add_pending_tick(1'b1);
    add_pending_tick(1'b1);
    add_pending_tick(1'b0);
    add_pending_tick(1'b1);
    add_pending_tick(1'b1);
    drain_sample_path();

    // Mixed extremes: the largest step (a phase that runs backward), the
    // smallest nonzero step, exactly one table address per tick, and a half
    // turn. A gain with only bit 15 set masks down to zero and silences its
    // tone; the smallest gain shows the rounding of negative products.
    write_reg(REG_TONE0_STEP, 32'hFFFF_FFFF);
    write_reg(REG_TONE1_STEP, 32'h0000_0001);
    write_reg(REG_TONE2_STEP, 32'h0040_0000);
    write_reg(REG_TONE3_STEP, 32'h8000_0000);
    write_reg(REG_TONE0_GAIN, 32'h0000_0001);
    write_reg(REG_TONE1_GAIN, 32'h0000_8000);
    write_reg(REG_TONE2_GAIN, 32'h0000_4000);
    write_reg(REG_TONE3_GAIN, 32'h7FFF_7FFF);
    @(posedge clk);
    cfg_we <= 1'b0;
    for (int i = 0; i < 8; i++) begin
      add_pending_tick(i != 3 && i != 6);
    end

    // Random part. The first pair of runs stalls the receiver hard, the next
    // pair starves the sender instead, and the last pair runs flat out.
    for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
      drain_sample_path();
      load_random_setting(seg == 0);
      case (seg / 2)
        0: begin
          send_idle_pct <= 25;
          recv_idle_pct <= 71;
        end
        1: begin
          send_idle_pct <= 71;
          recv_idle_pct <= 25;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (int i = 0; i < SEG_ITEMS; i++) begin
        // Halfway through one run the sender holds off until the output
        // side has caught up completely, then resumes.
        if (seg == 3 && i == SEG_ITEMS / 2) begin
          drain_sample_path();
        end
        add_pending_tick($urandom_range(99) < 85);
      end
    end

    drain_sample_path();
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // A hung handshake or a sample that never arrives ends here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_top: errors");
    $finish;
  end

endmodule

/* files.f */
rtl/core/mtss_pkg.sv
rtl/core/mtss_cell.sv
rtl/core/mtss_out_buf.sv
rtl/core/multi_tone_sine_synthesizer_core.sv
tb/tb_top.sv
